@@ hw/rtl/fpms_pkg.sv @@
// ----------------------------------------------------------------------------
// fpms_pkg
// Shared types and constants of the first pattern match search block.
// ----------------------------------------------------------------------------
package fpms_pkg;

	localparam int PATTERN_MAX_DEF   = 32;
	localparam int POSITION_BITS_DEF = 32;

	// pattern storage is fixed by the four 64-bit pattern registers
	localparam int PATTERN_BYTES = 32;
	localparam int PATTERN_W     = 8 * PATTERN_BYTES;
	localparam int LENGTH_W      = 6;
	localparam int POSITION_W    = 32;
	localparam int PADDR_W       = 6;
	localparam int PDATA_W       = 64;

	typedef enum logic [2:0] {
		REG_PATTERN_0 = 3'd0,
		REG_PATTERN_1 = 3'd1,
		REG_PATTERN_2 = 3'd2,
		REG_PATTERN_3 = 3'd3,
		REG_LENGTH    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic update;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic                  found;
		logic [POSITION_W-1:0] position;
	} result_t;

endpackage

@@ hw/rtl/fpms_cfg.sv @@
// ----------------------------------------------------------------------------
// fpms_cfg
// APB register file holding the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
module fpms_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fpms_pkg::PADDR_W-1:0]   paddr,
	input  logic [fpms_pkg::PDATA_W-1:0]   pwdata,
	output logic [fpms_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output logic [fpms_pkg::PATTERN_W-1:0] pattern,
	output logic [fpms_pkg::LENGTH_W-1:0]  length
);

	logic [fpms_pkg::PDATA_W-1:0]  word_q [4];
	logic [fpms_pkg::LENGTH_W-1:0] length_q;
	fpms_pkg::reg_idx_t            idx;
	logic                          wr_en;

	assign pready = 1'b1;
	assign idx    = fpms_pkg::reg_idx_t'(paddr[fpms_pkg::PADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q[0] <= '0;
			word_q[1] <= '0;
			word_q[2] <= '0;
			word_q[3] <= '0;
			length_q  <= fpms_pkg::LENGTH_W'(1);
		end else if (wr_en) begin
			case (idx)
				fpms_pkg::REG_PATTERN_0: word_q[0] <= pwdata;
				fpms_pkg::REG_PATTERN_1: word_q[1] <= pwdata;
				fpms_pkg::REG_PATTERN_2: word_q[2] <= pwdata;
				fpms_pkg::REG_PATTERN_3: word_q[3] <= pwdata;
				fpms_pkg::REG_LENGTH:    length_q  <= pwdata[fpms_pkg::LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			fpms_pkg::REG_PATTERN_0: prdata = word_q[0];
			fpms_pkg::REG_PATTERN_1: prdata = word_q[1];
			fpms_pkg::REG_PATTERN_2: prdata = word_q[2];
			fpms_pkg::REG_PATTERN_3: prdata = word_q[3];
			fpms_pkg::REG_LENGTH:    prdata = fpms_pkg::PDATA_W'(length_q);
			default:                 prdata = '0;
		endcase
	end

	assign pattern = {word_q[3], word_q[2], word_q[1], word_q[0]};
	assign length  = length_q;

endmodule

@@ hw/rtl/fpms_cell.sv @@
// ----------------------------------------------------------------------------
// fpms_cell
// One match cell: compares its pattern byte and holds one progress bit.
// ----------------------------------------------------------------------------
module fpms_cell #(
	parameter int INDEX    = 0,
	parameter int LEN_BITS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fpms_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          text_byte,
	input  logic [7:0]          pat_byte,
	input  logic [LEN_BITS-1:0] len_eff,
	input  logic                prev_bit,
	output logic                prog_bit,
	output logic                hit
);

	logic prog_q;
	logic prog_d;

	// bit k set when the last k+1 text bytes equal pattern bytes 0..k
	assign prog_d = prev_bit && (pat_byte == text_byte) && (LEN_BITS'(INDEX) < len_eff);
	assign hit    = prog_d && (LEN_BITS'(INDEX + 1) == len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= 1'b0;
		end else if (ctrl.clear) begin
			prog_q <= 1'b0;
		end else if (ctrl.update) begin
			prog_q <= prog_d;
		end
	end

	assign prog_bit = prog_q;

endmodule

@@ hw/rtl/fpms_outq.sv @@
// ----------------------------------------------------------------------------
// fpms_outq
// Two-entry result queue between the cell row and the result channel.
// ----------------------------------------------------------------------------
module fpms_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fpms_pkg::result_t push_data,
	output logic              full,
	output logic              result_valid,
	input  logic              result_stall,
	output fpms_pkg::result_t head
);

	fpms_pkg::result_t slot0_q;
	fpms_pkg::result_t slot1_q;
	logic [1:0]        count_q;
	logic              pop;

	assign result_valid = (count_q != 2'd0);
	assign full         = (count_q == 2'd2);
	assign pop          = result_valid && !result_stall;
	assign head         = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					slot0_q <= push_data;
				end else begin
					slot1_q <= push_data;
				end
			end
			2'b01: begin
				slot0_q <= slot1_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					slot0_q <= push_data;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= push_data;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/first_pattern_match_search_top.sv @@
// ----------------------------------------------------------------------------
// first_pattern_match_search_top
// Streams text bytes through a row of match cells and reports the first match.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle unless stalled, through a row of PATTERN_MAX
// cells, each comparing one pattern byte and passing its progress bit to the
// next cell. A result beat (found and start position, or not-found on the
// last byte) enters a two-entry queue in the cycle after its byte is
// accepted; text_stall rises only while both queue entries are held.
// Pattern and length are written over APB at 8*index and apply from the next
// byte; length 0 acts as 1 and lengths above PATTERN_MAX act as PATTERN_MAX.
module first_pattern_match_search_top #(
	parameter int PATTERN_MAX   = fpms_pkg::PATTERN_MAX_DEF,
	parameter int POSITION_BITS = fpms_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fpms_pkg::PADDR_W-1:0]    paddr,
	input  logic [fpms_pkg::PDATA_W-1:0]    pwdata,
	output logic [fpms_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	input  logic                            text_valid,
	output logic                            text_stall,
	input  logic [7:0]                      text_byte,
	input  logic                            is_last,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            found,
	output logic [fpms_pkg::POSITION_W-1:0] position
);

	localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

	logic [fpms_pkg::PATTERN_W-1:0] pattern;
	logic [fpms_pkg::LENGTH_W-1:0]  length_raw;
	logic [LEN_BITS-1:0]            len_eff;
	logic [LEN_BITS-1:0]            len_m1;
	logic [PATTERN_MAX-1:0]         prog;
	logic [PATTERN_MAX-1:0]         hits;
	logic [POSITION_BITS-1:0]       byte_counter_q;
	logic [POSITION_BITS-1:0]       start;
	logic                           already_found_q;
	logic                           accept;
	logic                           match;
	logic                           push;
	logic                           full;
	fpms_pkg::cell_ctrl_t           ctrl;
	fpms_pkg::result_t              res_d;
	fpms_pkg::result_t              head;

	fpms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pattern (pattern),
		.length  (length_raw)
	);

	always_comb begin
		if (length_raw == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (7'(length_raw) > 7'(PATTERN_MAX)) begin
			len_eff = LEN_BITS'(PATTERN_MAX);
		end else begin
			len_eff = LEN_BITS'(length_raw);
		end
	end

	assign accept      = text_valid && !text_stall;
	assign text_stall  = full;
	assign ctrl.update = accept && !already_found_q;
	assign ctrl.clear  = accept && is_last;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic prev_bit;
		if (k == 0) begin : g_head
			assign prev_bit = 1'b1;
		end else begin : g_link
			assign prev_bit = prog[k-1];
		end
		fpms_cell #(
			.INDEX    (k),
			.LEN_BITS (LEN_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.text_byte (text_byte),
			.pat_byte  (pattern[8*k +: 8]),
			.len_eff   (len_eff),
			.prev_bit  (prev_bit),
			.prog_bit  (prog[k]),
			.hit       (hits[k])
		);
	end

	assign match  = |hits;
	assign len_m1 = len_eff - LEN_BITS'(1);
	assign start  = byte_counter_q - POSITION_BITS'(len_m1);

	assign push           = ctrl.update && (match || is_last);
	assign res_d.found    = match;
	assign res_d.position = match ? fpms_pkg::POSITION_W'(start) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_counter_q  <= '0;
			already_found_q <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				byte_counter_q  <= '0;
				already_found_q <= 1'b0;
			end else begin
				if (byte_counter_q != '1) begin
					byte_counter_q <= byte_counter_q + POSITION_BITS'(1);
				end
				if (ctrl.update && match) begin
					already_found_q <= 1'b1;
				end
			end
		end
	end

	fpms_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_data    (res_d),
		.full         (full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign found    = head.found;
	assign position = head.position;

endmodule

@@ test/first_pattern_match_search_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_pattern_match_search_top_test
// Streams texts through the first pattern match search block under random
// handshake idling and checks every found / not-found report against a
// shift-and search model kept in the bench, across a series of patterns.
// ----------------------------------------------------------------------------
module first_pattern_match_search_top_test;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_beat_t;

	typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            psel         = 1'b0;
	logic                            penable      = 1'b0;
	logic                            pwrite       = 1'b0;
	logic [fpms_pkg::PADDR_W-1:0]    paddr        = '0;
	logic [fpms_pkg::PDATA_W-1:0]    pwdata       = '0;
	logic [fpms_pkg::PDATA_W-1:0]    prdata;
	logic                            pready;
	logic                            text_valid   = 1'b0;
	logic                            text_stall;
	logic [7:0]                      text_byte    = '0;
	logic                            is_last      = 1'b0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	logic                            found;
	logic [fpms_pkg::POSITION_W-1:0] position;

	first_pattern_match_search_top dut (.*);

	// search model state and its copy of the registers
	logic [fpms_pkg::PATTERN_W-1:0]     cfg_pattern = '0;
	logic [fpms_pkg::LENGTH_W-1:0]      cfg_length  = fpms_pkg::LENGTH_W'(1);
	logic [fpms_pkg::POSITION_W-1:0]    text_index  = '0;
	logic [fpms_pkg::PATTERN_BYTES-1:0] progress    = '0;
	logic                               match_seen  = 1'b0;

	fpms_pkg::result_t pending_reports[$];
	text_beat_t        text_queue[$];

	logic text_took      = 1'b0;
	logic quiet          = 1'b0;
	logic long_hold_req  = 1'b0;
	logic long_hold_used = 1'b0;
	int   text_gap       = 0;
	int   result_gap     = 0;
	int   hold_left      = 0;
	int   beats_queued   = 0;
	int   beats_taken    = 0;
	int   reports_checked = 0;
	int   reg_writes     = 0;
	int   mismatches     = 0;

	initial forever #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int active_length();
		if (cfg_length == 0)
			return 1;
		if (cfg_length > fpms_pkg::PATTERN_MAX_DEF)
			return fpms_pkg::PATTERN_MAX_DEF;
		return int'(cfg_length);
	endfunction

	function automatic void advance_search(logic [7:0] ch, logic last);
		int                                 len;
		logic [fpms_pkg::PATTERN_BYTES-1:0] nxt;
		fpms_pkg::result_t                  rep;
		len = active_length();
		nxt = '0;
		if (!match_seen) begin
			for (int k = 0; k < len; k++) begin
				if ((k == 0 || progress[k-1]) && cfg_pattern[8*k +: 8] == ch)
					nxt[k] = 1'b1;
			end
			progress = nxt;
			if (nxt[len-1]) begin
				rep.found    = 1'b1;
				rep.position = text_index - fpms_pkg::POSITION_W'(len - 1);
				pending_reports.push_back(rep);
				match_seen = 1'b1;
			end else if (last) begin
				rep.found    = 1'b0;
				rep.position = '0;
				pending_reports.push_back(rep);
			end
		end
		// last byte re-arms, otherwise the index counts up and sticks at all ones
		if (last) begin
			text_index = '0;
			progress   = '0;
			match_seen = 1'b0;
		end else if (text_index != '1) begin
			text_index = text_index + fpms_pkg::POSITION_W'(1);
		end
	endfunction

	// accepted beats feed the model, report beats are checked in order
	always @(posedge clk) begin
		fpms_pkg::result_t want;
		text_took <= text_valid && !text_stall;
		if (text_valid && !text_stall) begin
			advance_search(text_byte, is_last);
			beats_taken++;
		end
		if (result_valid && !result_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual found=%0b position=%0d",
					$time, found, position);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (found !== want.found) begin
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, want.found, found);
					mismatches++;
				end
				if (position !== want.position) begin
					$display("%0t: position mismatch, expected %0d, actual %0d",
						$time, want.position, position);
					mismatches++;
				end
				reports_checked++;
			end
		end
	end

	// text sender: holds a stalled beat, otherwise idles in bursts or sends the next one
	always @(negedge clk) begin
		text_beat_t nb;
		if (!text_valid || text_took) begin
			if (text_gap > 0) begin
				text_gap--;
				text_valid <= 1'b0;
			end else if (text_queue.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
				text_gap = $urandom_range(0, 6);
				text_valid <= 1'b0;
			end else if (text_queue.size() != 0) begin
				nb = text_queue.pop_front();
				text_valid <= 1'b1;
				text_byte  <= nb.ch;
				is_last    <= nb.last;
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// report receiver: one long hold on request, short random stall bursts otherwise
	always @(negedge clk) begin
		if (long_hold_req && !long_hold_used) begin
			long_hold_used = 1'b1;
			hold_left = 150;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (result_gap > 0) begin
			result_gap--;
			result_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			result_gap = $urandom_range(0, 6);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic write_reg(input fpms_pkg::reg_idx_t idx,
		input logic [fpms_pkg::PDATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == fpms_pkg::REG_LENGTH)
			cfg_length = value[fpms_pkg::LENGTH_W-1:0];
		else
			cfg_pattern[int'(idx)*64 +: 64] = value;
		reg_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic load_pattern(input logic [fpms_pkg::PDATA_W-1:0] len_word,
		input int letters, input fill_t fill);
		logic [fpms_pkg::PDATA_W-1:0] w;
		logic [7:0]                   base;
		base = 8'($urandom_range(0, 255 - letters));
		for (int r = 0; r < 4; r++) begin
			for (int k = 0; k < 8; k++) begin
				if (letters == 0)
					w[8*k +: 8] = 8'($urandom_range(0, 255));
				else
					w[8*k +: 8] = base + 8'($urandom_range(0, letters - 1));
			end
			if (fill == FILL_ONES)
				w = '1;
			else if (fill == FILL_ZEROS)
				w = '0;
			write_reg(fpms_pkg::reg_idx_t'(r), w);
		end
		write_reg(fpms_pkg::REG_LENGTH, len_word);
	endtask

	task automatic push_beat(input logic [7:0] ch, input logic last);
		text_beat_t b;
		b.ch   = ch;
		b.last = last;
		text_queue.push_back(b);
		beats_queued++;
	endtask

	// byte i of txt at bits 8i; ends marks the final byte as the text's last
	task automatic queue_short_text(input int n, input logic [63:0] txt, input logic ends);
		for (int i = 0; i < n; i++)
			push_beat(txt[8*i +: 8], ends && i == n - 1);
	endtask

	// mostly pattern bytes so partial matches and fall-backs happen often
	function automatic logic [7:0] text_char(int len);
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return cfg_pattern[8*$urandom_range(0, len - 1) +: 8];
	endfunction

	task automatic queue_random_text(input int max_len);
		logic [7:0] txt[$];
		int         n;
		int         len;
		int         at;
		len = active_length();
		n = $urandom_range(1, max_len);
		for (int i = 0; i < n; i++)
			txt.push_back(text_char(len));
		// two texts in three carry a planted copy of the pattern
		if ($urandom_range(0, 2) != 0) begin
			while (txt.size() < len)
				txt.push_back(text_char(len));
			at = $urandom_range(0, txt.size() - len);
			for (int k = 0; k < len; k++)
				txt[at + k] = cfg_pattern[8*k +: 8];
		end
		foreach (txt[i])
			push_beat(txt[i], i == txt.size() - 1);
	endtask

	task automatic wait_idle();
		while (beats_taken != beats_queued)
			@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		// trailing beats may give no report, so let the pipeline empty
		repeat (8)
			@(posedge clk);
	endtask

	initial begin
		int first;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset pattern is one zero byte
		queue_short_text(2, 64'h0000, 1'b1);
		queue_short_text(2, 64'h0005, 1'b1);
		queue_short_text(1, 64'h00FF, 1'b1);
		wait_idle();

		// ff 00 ff: match at the start with bytes after it, then a match on the last byte
		write_reg(fpms_pkg::REG_PATTERN_0, 64'h0000_0000_00FF_00FF);
		write_reg(fpms_pkg::REG_LENGTH, 64'd3);
		queue_short_text(5, 64'h0000_00FF_00FF_00FF, 1'b1);
		queue_short_text(6, 64'h0000_FF00_FF00_00FF, 1'b1);
		wait_idle();

		// length field zero acts as one
		write_reg(fpms_pkg::REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0);
		queue_short_text(2, 64'h0000_0000_0000_FF00, 1'b1);
		wait_idle();

		// length above the maximum saturates, short text cannot match
		write_reg(fpms_pkg::REG_LENGTH, 64'h0000_0000_0000_003F);
		queue_short_text(3, 64'h0000_0000_00FF_00FF, 1'b1);
		wait_idle();

		// pattern change in the middle of a text keeps the progress
		write_reg(fpms_pkg::REG_PATTERN_0, 64'h0000_0000_0000_4241);
		write_reg(fpms_pkg::REG_LENGTH, 64'd2);
		queue_short_text(1, 64'h0000_0000_0000_0041, 1'b0);
		wait_idle();
		write_reg(fpms_pkg::REG_PATTERN_0, 64'h0000_0000_0000_4341);
		queue_short_text(1, 64'h0000_0000_0000_0043, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: load_pattern(64'd1, 0, FILL_RANDOM);
				1: load_pattern(64'd1, 2, FILL_RANDOM);
				2: load_pattern(64'd32, 0, FILL_ONES);
				3: load_pattern(64'($urandom_range(2, 6)), 2, FILL_RANDOM);
				4: load_pattern(64'hFFFF_FFFF_FFFF_FFC0, 3, FILL_RANDOM);
				5: load_pattern(64'($urandom_range(33, 63)), 0, FILL_RANDOM);
				6: load_pattern(64'($urandom_range(9, 31)), 3, FILL_RANDOM);
				7: load_pattern(64'd32, 0, FILL_ZEROS);
				8: load_pattern(64'($urandom_range(1, 32)), 4, FILL_RANDOM);
				default: begin
					load_pattern(64'($urandom_range(2, 8)), 2, FILL_RANDOM);
					quiet = 1'b1;
				end
			endcase
			// short texts with a long report hold fill the block until it stalls text
			if (ph == 1)
				long_hold_req = 1'b1;
			first = beats_queued;
			while (beats_queued - first < 48)
				queue_random_text(ph == 1 ? 3 : 2 * active_length() + 8);
			wait_idle();
		end

		$display("checked %0d search reports from %0d text beats under %0d register writes",
			reports_checked, beats_taken, reg_writes);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/fpms_pkg.sv
hw/rtl/fpms_cfg.sv
hw/rtl/fpms_cell.sv
hw/rtl/fpms_outq.sv
hw/rtl/first_pattern_match_search_top.sv
test/first_pattern_match_search_top_test.sv
